/* design/integer_to_decimal_ascii_assert.svh */
// Assertion macros for the decimal ASCII formatter.
`ifndef INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH
`define INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH

// Checked outside reset.
`define I2DA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define I2DA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* design/i2da_pkg.sv */
// Package: constants, payload types and the double-dabble step of the decimal ASCII formatter.
package i2da_pkg;

    localparam int VALUE_W     = 32;
    localparam int BUF_W       = 8;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 4;
    localparam int DIGITS      = 10;
    localparam int CONV_DIGITS = 10;
    localparam int KEPT_DIGITS = (DIGITS < CONV_DIGITS) ? DIGITS : CONV_DIGITS;
    localparam int DIG_IDX_W   = $clog2(CONV_DIGITS);
    localparam int NDIG_W      = $clog2(CONV_DIGITS + 1);
    localparam int DI_W        = DIG_IDX_W + 1;
    localparam int MAX_CAP     = 12;
    localparam int CAP_W       = $clog2(MAX_CAP + 1);
    localparam int TEXT_LEN    = MAX_CAP - 1;
    localparam int DD_STEPS    = 4;
    localparam int DD_STAGES   = VALUE_W / DD_STEPS;
    localparam int SR_W        = 4 * CONV_DIGITS + VALUE_W;

    localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_NUL   = 8'h00;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] value;
        logic [BUF_W-1:0]   buffer_size;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic [POS_W-1:0]  position;
        logic              last;
    } result_t;

    typedef struct packed {
        logic             neg;
        logic [CAP_W-1:0] cap;
        logic [SR_W-1:0]  sr;
    } work_t;

    typedef struct packed {
        logic                             neg;
        logic [CAP_W-1:0]                 cap;
        logic [CONV_DIGITS-1:0][3:0]      digits;
        logic [NDIG_W-1:0]                ndig;
    } digit_t;

    typedef struct packed {
        logic [POS_W-1:0]                 keep;
        logic [TEXT_LEN-1:0][CHAR_W-1:0]  text;
    } text_item_t;

    // One shift-add-3 iteration over BCD digits above the binary part.
    function automatic logic [SR_W-1:0] dd_step(input logic [SR_W-1:0] sr);
        logic [SR_W-1:0] t;
        t = sr;
        for (int d = 0; d < CONV_DIGITS; d++) begin
            if (t[VALUE_W + 4*d +: 4] >= 4'd5) begin
                t[VALUE_W + 4*d +: 4] = t[VALUE_W + 4*d +: 4] + 4'd3;
            end
        end
        return {t[SR_W-2:0], 1'b0};
    endfunction

endpackage

/* design/i2da_convert.sv */
// Conversion pipeline: sign handling, pipelined double dabble, digit count and text build.
module i2da_convert import i2da_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  item_t      in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output text_item_t out_item
);

    logic                 p0_valid_reg;
    work_t                p0_reg;
    work_t                p0_next;
    logic [DD_STAGES-1:0] dd_valid_reg;
    work_t                dd_reg  [DD_STAGES];
    work_t                dd_next [DD_STAGES];
    work_t                stage_in [DD_STAGES+1];
    logic [DD_STAGES:0]   stage_in_valid;
    logic [DD_STAGES:0]   adv_chain;
    logic                 f_valid_reg;
    digit_t               f_reg;
    digit_t               f_next;
    logic                 t_valid_reg;
    text_item_t           t_reg;
    text_item_t           t_next;
    logic                 t_adv;
    logic                 f_adv;
    logic                 p0_adv;

    // Stall chain: a stage moves when it is empty or its successor moves.
    always_comb begin
        t_adv = !t_valid_reg || out_ready;
        f_adv = !f_valid_reg || t_adv;
        adv_chain[DD_STAGES] = f_adv;
        for (int k = DD_STAGES - 1; k >= 0; k--) begin
            adv_chain[k] = !dd_valid_reg[k] || adv_chain[k+1];
        end
        p0_adv = !p0_valid_reg || adv_chain[0];
    end

    assign in_ready  = p0_adv;
    assign out_valid = t_valid_reg;
    assign out_item  = t_reg;

    // Input stage: clamp capacity, take magnitude.
    always_comb begin
        logic neg;
        neg = in_item.operation & in_item.value[VALUE_W-1];
        p0_next.neg = neg;
        p0_next.cap = (in_item.buffer_size > BUF_W'(MAX_CAP)) ? CAP_W'(MAX_CAP)
                                                               : in_item.buffer_size[CAP_W-1:0];
        p0_next.sr  = {{(4*CONV_DIGITS){1'b0}},
                       (neg ? (~in_item.value + VALUE_W'(1)) : in_item.value)};
    end

    // Double dabble stages.
    always_comb begin
        stage_in[0]       = p0_reg;
        stage_in_valid[0] = p0_valid_reg;
        for (int k = 0; k < DD_STAGES; k++) begin
            stage_in[k+1]       = dd_reg[k];
            stage_in_valid[k+1] = dd_valid_reg[k];
        end
        for (int k = 0; k < DD_STAGES; k++) begin
            dd_next[k] = stage_in[k];
            for (int s = 0; s < DD_STEPS; s++) begin
                dd_next[k].sr = dd_step(dd_next[k].sr);
            end
        end
    end

    // Digit count stage.
    always_comb begin
        f_next.neg    = stage_in[DD_STAGES].neg;
        f_next.cap    = stage_in[DD_STAGES].cap;
        f_next.digits = stage_in[DD_STAGES].sr[SR_W-1:VALUE_W];
        f_next.ndig   = NDIG_W'(1);
        for (int i = 0; i < KEPT_DIGITS; i++) begin
            if (f_next.digits[i] != 4'd0) begin
                f_next.ndig = NDIG_W'(i + 1);
            end
        end
    end

    // Text build stage.
    always_comb begin
        logic [POS_W-1:0] len;
        logic [POS_W-1:0] capm1;
        logic [DI_W-1:0]  di;
        len   = POS_W'(f_reg.ndig) + POS_W'(f_reg.neg);
        capm1 = POS_W'(f_reg.cap) - POS_W'(1);
        t_next.keep = (capm1 < len) ? capm1 : len;
        for (int i = 0; i < TEXT_LEN; i++) begin
            di = DI_W'(f_reg.ndig) + DI_W'(f_reg.neg) - DI_W'(i) - DI_W'(1);
            if (f_reg.neg && i == 0) begin
                t_next.text[i] = CHR_MINUS;
            end else if (di < DI_W'(CONV_DIGITS)) begin
                t_next.text[i] = CHR_ZERO + CHAR_W'(f_reg.digits[di[DIG_IDX_W-1:0]]);
            end else begin
                t_next.text[i] = CHR_ZERO;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            dd_valid_reg <= '0;
            f_valid_reg  <= 1'b0;
            t_valid_reg  <= 1'b0;
        end else begin
            if (p0_adv) begin
                p0_valid_reg <= in_valid;
            end
            for (int k = 0; k < DD_STAGES; k++) begin
                if (adv_chain[k]) begin
                    dd_valid_reg[k] <= stage_in_valid[k];
                end
            end
            if (f_adv) begin
                f_valid_reg <= stage_in_valid[DD_STAGES];
            end
            if (t_adv) begin
                // capacity zero produces no output at all
                t_valid_reg <= f_valid_reg && (f_reg.cap != CAP_W'(0));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p0_adv) begin
            p0_reg <= p0_next;
        end
        for (int k = 0; k < DD_STAGES; k++) begin
            if (adv_chain[k]) begin
                dd_reg[k] <= dd_next[k];
            end
        end
        if (f_adv) begin
            f_reg <= f_next;
        end
        if (t_adv) begin
            t_reg <= t_next;
        end
    end

endmodule

/* design/i2da_serial.sv */
// Serializer: emits one character per transaction from a built text, then the terminator.
module i2da_serial import i2da_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  text_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_result
);

    logic             busy_reg;
    logic [POS_W-1:0] idx_reg;
    text_item_t       item_reg;
    logic             m_valid_reg;
    result_t          m_result_reg;
    result_t          m_result_next;
    logic             slot_free;
    logic             emit;
    logic             finishing;

    assign slot_free = !m_valid_reg || out_ready;
    assign emit      = busy_reg && slot_free;
    assign finishing = emit && (idx_reg == item_reg.keep);
    assign in_ready  = !busy_reg || finishing;

    assign out_valid  = m_valid_reg;
    assign out_result = m_result_reg;

    always_comb begin
        m_result_next.position = idx_reg;
        m_result_next.last     = (idx_reg == item_reg.keep);
        if (idx_reg == item_reg.keep || idx_reg >= POS_W'(TEXT_LEN)) begin
            m_result_next.character = CHR_NUL;
        end else begin
            m_result_next.character = item_reg.text[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (finishing) begin
                busy_reg <= 1'b0;
            end else if (emit) begin
                idx_reg <= idx_reg + POS_W'(1);
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (slot_free) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_result_reg <= m_result_next;
        end
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

/* design/integer_to_decimal_ascii.sv */
// Top level of the 32-bit decimal ASCII formatter.
// Input channel s_valid/s_ready/s_item: one transaction per number, carrying the
// signed/unsigned selector, the 32-bit value and the destination buffer size.
// Result channel m_valid/m_ready/m_result: one transaction per character, with its
// position; the NUL terminator carries last. Buffer size 0 gives no transaction,
// sizes above 12 act as 12.
// Path to the first character: 8 double-dabble stages after the input register,
// digit count, text build, serializer text register, output register.
// Throughput: one character per cycle while m_ready is high. A number gives one
// transaction per character including the terminator (1 to 12); the next number's
// text waits in the pipeline and follows right after the previous terminator.
// Reset (aresetn low, synchronous) empties the pipeline and the serializer.
// When m_ready is low the output holds and the pipeline fills up, then s_ready
// drops; nothing is lost or repeated.
module integer_to_decimal_ascii import i2da_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  item_t   s_item,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

`include "integer_to_decimal_ascii_assert.svh"

    logic       text_valid;
    logic       text_ready;
    text_item_t text_item;

    i2da_convert u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_valid (text_valid),
        .out_ready (text_ready),
        .out_item  (text_item)
    );

    i2da_serial u_serial (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (text_valid),
        .in_ready   (text_ready),
        .in_item    (text_item),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (m_result)
    );

    `I2DA_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")
    `I2DA_ASSERT(a_keep_range, text_valid && text_ready |-> text_item.keep <= POS_W'(TEXT_LEN), "text length out of range")
    `I2DA_ASSERT(a_run_continues, m_valid && m_ready && !m_result.last |=> m_valid && (m_result.position == $past(m_result.position) + POS_W'(1)), "character run broken")
    `I2DA_ASSERT(a_minus_first, m_valid && m_result.character == CHR_MINUS |-> m_result.position == '0, "minus sign not at start")

endmodule

/* sim/i2da_char_checker.sv */
// Checker for the decimal ASCII formatter: predicts each character run and compares it.
module i2da_char_checker import i2da_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_ready,
    input  item_t   s_item,
    input  logic    m_valid,
    input  logic    m_ready,
    input  result_t m_result,
    output int      fail_count,
    output int      pending_chars
);

    result_t expected_chars[$];

    // Build the text of one number and queue its characters plus the terminator.
    function automatic void format_decimal(input item_t it);
        logic [CHAR_W-1:0] text [DIGITS+2];
        logic [3:0]        dig [DIGITS];
        logic [63:0]       mag;
        int                cap;
        int                len;
        int                ndig;
        int                keep;
        result_t           r;
        cap = (it.buffer_size > MAX_CAP) ? MAX_CAP : int'(it.buffer_size);
        if (cap == 0) return;
        len  = 0;
        ndig = 1;
        mag  = {32'b0, it.value};
        if (it.operation && it.value[VALUE_W-1]) begin
            text[len] = CHR_MINUS;
            len++;
            mag = {32'b0, ~it.value + 32'd1};
        end
        for (int i = 0; i < DIGITS; i++) begin
            dig[i] = 4'(mag % 10);
            mag    = mag / 10;
            if (dig[i] != 0) ndig = i + 1;
        end
        for (int i = ndig; i > 0; i--) begin
            text[len] = CHR_ZERO + CHAR_W'(dig[i-1]);
            len++;
        end
        keep = (cap - 1 < len) ? cap - 1 : len;
        for (int i = 0; i < keep; i++) begin
            r.character = text[i];
            r.position  = POS_W'(i);
            r.last      = 1'b0;
            expected_chars.push_back(r);
        end
        r.character = CHR_NUL;
        r.position  = POS_W'(keep);
        r.last      = 1'b1;
        expected_chars.push_back(r);
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            expected_chars.delete();
            fail_count = 0;
        end else begin
            if (s_valid && s_ready) format_decimal(s_item);
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction: char %02h pos %0d last %0b",
                                 m_result.character, m_result.position, m_result.last);
                end else begin
                    want = expected_chars.pop_front();
                    if (want.character !== m_result.character ||
                        want.position !== m_result.position ||
                        want.last !== m_result.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected char %02h pos %0d last %0b, got char %02h pos %0d last %0b",
                                     want.character, want.position, want.last,
                                     m_result.character, m_result.position, m_result.last);
                    end
                end
            end
        end
        pending_chars = expected_chars.size();
    end

endmodule

/* sim/tb.sv */
// Testbench top for the decimal ASCII formatter: stimulus, flow control and verdict.
module tb import i2da_pkg::*;;

    localparam int ITEM_COUNT  = 310;
    localparam int CYCLE_LIMIT = 200000;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    item_t   s_item  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_result;
    int      fail_count;
    int      pending_chars;
    int      cycle_count = 0;
    int      burst_left  = 0;
    int      ready_mode  = 0;
    int      mode_left   = 0;

    always #5 aclk = ~aclk;

    integer_to_decimal_ascii u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    i2da_char_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver backpressure: one of four ready modes, picked anew each time mode_left runs out
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 128);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic item_t mk_item(input logic op, input logic [31:0] v,
                                      input logic [7:0] sz);
        item_t it;
        it.operation   = op;
        it.value       = v;
        it.buffer_size = sz;
        return it;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        int          k;
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 99);
            2: begin
                p = 32'd1;
                k = $urandom_range(0, 9);
                repeat (k) p = p * 10;
                p = p + $urandom_range(0, 2) - 1;
                return ($urandom_range(0, 1) != 0) ? ~p + 32'd1 : p;
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: p = 32'h8000_0000;
                    1: p = 32'h7FFF_FFFF;
                    2: p = 32'hFFFF_FFFF;
                    default: p = 32'h0;
                endcase
                return p + $urandom_range(0, 4) - 2;
            end
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [7:0] pick_size();
        case ($urandom_range(0, 9))
            7, 8: return 8'($urandom_range(11, 12));
            9: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, 13));
        endcase
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(mk_item(1'b0, 32'd0, 8'd12));
        send_item(mk_item(1'b0, 32'hFFFF_FFFF, 8'd12));
        send_item(mk_item(1'b1, 32'hFFFF_FFFF, 8'd12));
        send_item(mk_item(1'b1, 32'h8000_0000, 8'd12));
        send_item(mk_item(1'b0, 32'h8000_0000, 8'd12));
        send_item(mk_item(1'b1, 32'h7FFF_FFFF, 8'd12));
        send_item(mk_item(1'b1, 32'd0, 8'd12));
        send_item(mk_item(1'b0, 32'd1234567890, 8'd0));
        send_item(mk_item(1'b1, 32'h8000_0000, 8'd1));
        send_item(mk_item(1'b1, 32'hFFFF_FF85, 8'd2));
        send_item(mk_item(1'b1, 32'hFFFF_FF85, 8'd3));
        send_item(mk_item(1'b0, 32'hFFFF_FFFF, 8'd11));
        send_item(mk_item(1'b1, 32'h8000_0000, 8'd11));
        send_item(mk_item(1'b0, 32'd9, 8'd13));
        send_item(mk_item(1'b0, 32'd10, 8'd255));
        send_item(mk_item(1'b0, 32'd1000000000, 8'd200));
        send_item(mk_item(1'b1, 32'd999999999, 8'd5));
        send_item(mk_item(1'b0, 32'd42, 8'd2));
        send_item(mk_item(1'b1, 32'hFFFF_FFF6, 8'd4));
        send_item(mk_item(1'b0, 32'd7, 8'd1));
        send_item(mk_item(1'b1, 32'd5, 8'd0));
        send_item(mk_item(1'b0, 32'd100, 8'd128));
        send_item(mk_item(1'b1, 32'h5555_5555, 8'h55));
        send_item(mk_item(1'b0, 32'hAAAA_AAAA, 8'hAA));

        for (int n = 0; n < ITEM_COUNT - 24; n++)
            send_item(mk_item(1'($urandom_range(0, 1)), pick_value(), pick_size()));
        s_valid <= 1'b0;

        @(negedge aclk);
        while (pending_chars != 0) @(negedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0 && pending_chars == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/i2da_pkg.sv
design/i2da_convert.sv
design/i2da_serial.sv
design/integer_to_decimal_ascii.sv
sim/i2da_char_checker.sv
sim/tb.sv
